/* sv/rfaa_pkg.sv */
package rfaa_pkg;

    localparam int unsigned ACC_W    = 32;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic REG_AVERAGE_SHIFT   = 1'b0;
    localparam logic REG_BYTE_SWAP_INPUT = 1'b1;

    localparam logic [SHIFT_W-1:0] AVERAGE_SHIFT_RESET = 3'd1;

    typedef struct packed {
        logic [1:0]          mode;
        logic [INDEX_W-1:0]  pixel_index;
        logic [SAMPLE_W-1:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_value;
        logic [INDEX_W-1:0]  out_index;
    } avg_item_t;

endpackage

/* sv/raw_frame_accumulate_average.sv */
// A read item's result takes the path RAM read, forward and register, update,
// and then the output register; a stalled output holds it there.
// Throughput: one item per cycle unless stalled; separate RAM read, write ports.
// Each accumulator update is forwarded from the two stages ahead of the read.
// Reset clears the pipeline valid bits, the output stage and the registers
// (shift 1, no byte swap); accumulator contents stay undefined until loaded.
module raw_frame_accumulate_average_core #(
    parameter int unsigned MAX_PIXELS = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  rfaa_pkg::pix_item_t                 pix,
    output logic                                avg_valid,
    input  logic                                avg_stall,
    output rfaa_pkg::avg_item_t                 avg,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rfaa_pkg::APB_AW-1:0]         paddr,
    input  logic [rfaa_pkg::APB_DW-1:0]         pwdata,
    output logic [rfaa_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int unsigned INDEX_SPAN  = 1 << rfaa_pkg::INDEX_W;
    localparam int unsigned STORE_DEPTH = (MAX_PIXELS < INDEX_SPAN) ? MAX_PIXELS : INDEX_SPAN;
    localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [rfaa_pkg::SHIFT_W-1:0]  avg_shift_reg, avg_shift_next;
    logic                          byte_swap_reg, byte_swap_next;

    logic                          b_valid_reg, b_valid_next;
    logic [1:0]                    b_mode_reg, b_mode_next;
    logic [rfaa_pkg::INDEX_W-1:0]  b_idx_reg, b_idx_next;
    logic [rfaa_pkg::SAMPLE_W-1:0] b_sample_reg, b_sample_next;

    logic                          c_valid_reg, c_valid_next;
    logic [1:0]                    c_mode_reg, c_mode_next;
    logic [rfaa_pkg::INDEX_W-1:0]  c_idx_reg, c_idx_next;
    logic [rfaa_pkg::SAMPLE_W-1:0] c_sample_reg, c_sample_next;
    logic [rfaa_pkg::ACC_W-1:0]    c_old_reg, c_old_next;

    logic                          d_valid_reg, d_valid_next;
    logic                          d_read_reg, d_read_next;
    logic [rfaa_pkg::INDEX_W-1:0]  d_idx_reg, d_idx_next;
    logic [rfaa_pkg::ACC_W-1:0]    d_acc_reg, d_acc_next;

    logic                          out_valid_reg, out_valid_next;
    rfaa_pkg::avg_item_t           out_reg, out_next;
    logic                          skid_valid_reg, skid_valid_next;
    rfaa_pkg::avg_item_t           skid_reg, skid_next;

    logic                          en;
    logic                          accept;
    logic                          in_range;
    logic [rfaa_pkg::SAMPLE_W-1:0] sample_in;
    logic [rfaa_pkg::ACC_W-1:0]    ram_rdata;
    logic [rfaa_pkg::ACC_W-1:0]    c_new;
    logic [rfaa_pkg::SHIFT_W-1:0]  shift_eff;
    logic [rfaa_pkg::ACC_W-1:0]    round_sum;
    logic                          cfg_wr;
    logic                          take;
    logic                          d_push;
    rfaa_pkg::avg_item_t           d_item;

    assign en        = !skid_valid_reg;
    assign pix_stall = skid_valid_reg;
    assign accept    = pix_valid && en;
    assign in_range  = ({16'd0, pix.pixel_index} < 32'(STORE_DEPTH));
    assign sample_in = byte_swap_reg ? {pix.pixel_value[7:0], pix.pixel_value[15:8]}
                                     : pix.pixel_value;

    rfaa_ram #(
        .WIDTH (rfaa_pkg::ACC_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (en && c_valid_reg),
        .waddr (c_idx_reg[ADDR_W-1:0]),
        .wdata (c_new),
        .re    (en),
        .raddr (pix.pixel_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign shift_eff = (avg_shift_reg == '0) ? 3'd1 : avg_shift_reg;
    assign round_sum = c_old_reg + (32'd1 << (shift_eff - 3'd1));

    always_comb
    begin
        case (c_mode_reg)
            rfaa_pkg::MODE_LOAD: c_new = {16'd0, c_sample_reg};
            rfaa_pkg::MODE_ADD:  c_new = c_old_reg + {16'd0, c_sample_reg};
            default:             c_new = round_sum >> shift_eff;
        endcase
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        avg_shift_next = avg_shift_reg;
        byte_swap_next = byte_swap_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                rfaa_pkg::REG_AVERAGE_SHIFT:   avg_shift_next = pwdata[2:0];
                rfaa_pkg::REG_BYTE_SWAP_INPUT: byte_swap_next = pwdata[0];
                default:                       avg_shift_next = avg_shift_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rfaa_pkg::REG_AVERAGE_SHIFT:   prdata = {29'd0, avg_shift_reg};
            rfaa_pkg::REG_BYTE_SWAP_INPUT: prdata = {31'd0, byte_swap_reg};
            default:                       prdata = '0;
        endcase
    end

    always_comb
    begin
        b_valid_next  = b_valid_reg;
        b_mode_next   = b_mode_reg;
        b_idx_next    = b_idx_reg;
        b_sample_next = b_sample_reg;
        c_valid_next  = c_valid_reg;
        c_mode_next   = c_mode_reg;
        c_idx_next    = c_idx_reg;
        c_sample_next = c_sample_reg;
        c_old_next    = c_old_reg;
        d_valid_next  = d_valid_reg;
        d_read_next   = d_read_reg;
        d_idx_next    = d_idx_reg;
        d_acc_next    = d_acc_reg;
        if (en)
        begin
            b_valid_next  = accept && in_range && (pix.mode != rfaa_pkg::MODE_UNUSED);
            b_mode_next   = pix.mode;
            b_idx_next    = pix.pixel_index;
            b_sample_next = sample_in;

            c_valid_next  = b_valid_reg;
            c_mode_next   = b_mode_reg;
            c_idx_next    = b_idx_reg;
            c_sample_next = b_sample_reg;
            if (c_valid_reg && (c_idx_reg == b_idx_reg))
            begin
                c_old_next = c_new;
            end
            else if (d_valid_reg && (d_idx_reg == b_idx_reg))
            begin
                c_old_next = d_acc_reg;
            end
            else
            begin
                c_old_next = ram_rdata;
            end

            d_valid_next = c_valid_reg;
            d_read_next  = (c_mode_reg == rfaa_pkg::MODE_READ);
            d_idx_next   = c_idx_reg;
            d_acc_next   = c_new;
        end
    end

    assign take   = out_valid_reg && !avg_stall;
    assign d_push = en && d_valid_reg && d_read_reg;
    assign d_item = '{average_value: d_acc_reg[15:0], out_index: d_idx_reg};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (d_push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_next       = d_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = d_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_shift_reg  <= rfaa_pkg::AVERAGE_SHIFT_RESET;
            byte_swap_reg  <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            avg_shift_reg  <= avg_shift_next;
            byte_swap_reg  <= byte_swap_next;
            b_valid_reg    <= b_valid_next;
            c_valid_reg    <= c_valid_next;
            d_valid_reg    <= d_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_mode_reg   <= b_mode_next;
        b_idx_reg    <= b_idx_next;
        b_sample_reg <= b_sample_next;
        c_mode_reg   <= c_mode_next;
        c_idx_reg    <= c_idx_next;
        c_sample_reg <= c_sample_next;
        c_old_reg    <= c_old_next;
        d_read_reg   <= d_read_next;
        d_idx_reg    <= d_idx_next;
        d_acc_reg    <= d_acc_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    assign avg_valid = out_valid_reg;
    assign avg       = out_reg;

endmodule

/* sv/rfaa_ram.sv */
module rfaa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rfaa_checker.sv */
module rfaa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pix_stall,
    input logic                avg_valid,
    input logic                avg_stall,
    input rfaa_pkg::avg_item_t avg,
    input logic                psel,
    input logic                pready
);

    // The input side only stalls while a result is waiting at the output.
    a_stall_needs_result: assert property (
        @(posedge clk) disable iff (!rst_n) pix_stall |-> avg_valid
    ) else $error("input stalled with no result waiting");

    // A taken result frees the spare slot, so the input stall clears next cycle.
    a_stall_clears: assert property (
        @(posedge clk) disable iff (!rst_n) (pix_stall && !avg_stall) |=> !pix_stall
    ) else $error("input stall held after result was taken");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n) (avg_valid && avg_stall) |=> (avg_valid && $stable(avg))
    ) else $error("stalled result dropped or changed");

    a_no_wait_state: assert property (
        @(posedge clk) disable iff (!rst_n) psel |-> pready
    ) else $error("configuration access inserted a wait state");

endmodule

bind raw_frame_accumulate_average_core rfaa_checker u_rfaa_checker (.*);

/* sim/tb_raw_frame_accumulate_average_core.sv */
`timescale 1ns / 1ps

module tb_raw_frame_accumulate_average_core;
    import rfaa_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_AVERAGE_SHIFT = {REG_AVERAGE_SHIFT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_BYTE_SWAP = {REG_BYTE_SWAP_INPUT, 2'b00};
    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_PHASES = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_style_t;

    typedef struct {
        bit                  is_cfg;
        logic [APB_AW-1:0]   addr;
        logic [APB_DW-1:0]   data;
        pix_item_t           item;
        bit                  typed;
        avg_item_t           result;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                pix_valid;
    logic                pix_stall;
    pix_item_t           pix;
    logic                avg_valid;
    logic                avg_stall;
    avg_item_t           avg;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic [31:0]         acc_store [int];
    logic [SHIFT_W-1:0]  shift_setting;
    logic                swap_setting;
    avg_item_t           averages_due [$];
    stim_row_t           directed_rows [$];

    int unsigned         error_count;
    int unsigned         idle_cycles;
    int unsigned         burst_left;
    bit                  gaps_on;
    stall_style_t        stall_style;
    int unsigned         stall_pct;
    int unsigned         stall_period;
    int unsigned         stall_duty;
    int unsigned         stall_phase;
    bit                  apb_busy;

    raw_frame_accumulate_average_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .avg_valid (avg_valid),
        .avg_stall (avg_stall),
        .avg       (avg),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void accumulate_pixel(pix_item_t it, bit typed, avg_item_t typed_avg);
        logic [15:0] sample;
        logic [31:0] sum;
        int unsigned sh;
        int          idx;
        avg_item_t   due;
        begin
            idx = int'(it.pixel_index);
            sample = swap_setting ? {it.pixel_value[7:0], it.pixel_value[15:8]}
                                  : it.pixel_value;
            case (it.mode)
                MODE_LOAD: acc_store[idx] = {16'h0000, sample};
                MODE_ADD:  acc_store[idx] = acc_store[idx] + {16'h0000, sample};
                MODE_READ:
                begin
                    sh = (shift_setting == 0) ? 1 : int'(shift_setting);
                    sum = acc_store[idx] + (32'd1 << (sh - 1));
                    sum = sum >> sh;
                    acc_store[idx] = sum;
                    due.average_value = sum[15:0];
                    due.out_index = it.pixel_index;
                    averages_due.push_back(typed ? typed_avg : due);
                end
                default: ;
            endcase
        end
    endfunction

    task automatic send_pixel(pix_item_t it, bit typed, avg_item_t typed_avg);
        int unsigned gap;
        begin
            if (gaps_on && burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                @(negedge clk);
                pix_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            @(negedge clk);
            pix <= it;
            pix_valid <= 1'b1;
            do
                @(posedge clk);
            while (pix_stall);
            accumulate_pixel(it, typed, typed_avg);
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    task automatic send_plain(logic [1:0] mode, logic [15:0] idx, logic [15:0] value);
        pix_item_t it;
        avg_item_t none;
        begin
            it.mode = mode;
            it.pixel_index = idx;
            it.pixel_value = value;
            none = '0;
            send_pixel(it, 1'b0, none);
        end
    endtask

    task automatic wait_for_averages(bit settle);
        begin
            @(negedge clk);
            pix_valid <= 1'b0;
            while (averages_due.size() != 0)
                @(posedge clk);
            if (settle)
                repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        begin
            apb_busy = 1'b1;
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= addr;
            pwdata <= data;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (addr == ADDR_AVERAGE_SHIFT)
                shift_setting = data[SHIFT_W-1:0];
            else if (addr == ADDR_BYTE_SWAP)
                swap_setting = data[0];
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            apb_busy = 1'b0;
        end
    endtask

    task automatic add_pix_row(logic [1:0] mode, logic [15:0] idx, logic [15:0] value,
                               bit typed, logic [15:0] avg_value);
        stim_row_t row;
        begin
            row = '{default: '0};
            row.item.mode = mode;
            row.item.pixel_index = idx;
            row.item.pixel_value = value;
            row.typed = typed;
            row.result.average_value = avg_value;
            row.result.out_index = idx;
            directed_rows.push_back(row);
        end
    endtask

    task automatic add_cfg_row(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        stim_row_t row;
        begin
            row = '{default: '0};
            row.is_cfg = 1'b1;
            row.addr = addr;
            row.data = data;
            directed_rows.push_back(row);
        end
    endtask

    function automatic logic [15:0] random_sample();
        int unsigned pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                random_sample = 16'hFFFF;
            else if (pick == 1)
                random_sample = 16'h0000;
            else
                random_sample = 16'($urandom);
        end
    endfunction

    task automatic send_noise(const ref logic [15:0] pool [$]);
        logic [15:0] idx;
        logic [1:0]  mode;
        begin
            if ($urandom_range(0, 1) == 0)
                idx = pool[$urandom_range(0, pool.size() - 1)];
            else
                idx = 16'($urandom);
            if (acc_store.exists(int'(idx)))
                mode = 2'($urandom_range(0, 3));
            else
                mode = ($urandom_range(0, 1) == 0) ? MODE_LOAD : MODE_UNUSED;
            send_plain(mode, idx, 16'($urandom));
        end
    endtask

    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case (stall_style)
            STALL_RANDOM:   avg_stall <= ($urandom_range(0, 99) < stall_pct);
            STALL_PERIODIC: avg_stall <= ((stall_phase % stall_period) < stall_duty);
            default:        avg_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && avg_valid && !avg_stall)
        begin
            if (averages_due.size() == 0)
            begin
                $error("unexpected average: index %h value %h", avg.out_index,
                       avg.average_value);
                error_count++;
            end
            else
            begin
                if (avg.average_value !== averages_due[0].average_value)
                begin
                    $error("average_value: expected %h, got %h",
                           averages_due[0].average_value, avg.average_value);
                    error_count++;
                end
                if (avg.out_index !== averages_due[0].out_index)
                begin
                    $error("out_index: expected %h, got %h",
                           averages_due[0].out_index, avg.out_index);
                    error_count++;
                end
                void'(averages_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (avg_valid && !avg_stall) || apb_busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_raw_frame_accumulate_average_core NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] pixel_pool [$];
        int unsigned npix;
        int unsigned frames;
        logic [2:0]  new_shift;
        stim_row_t   row;

        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        gaps_on = 1'b1;
        stall_style = STALL_RANDOM;
        stall_pct = 30;
        stall_period = 5;
        stall_duty = 2;
        apb_busy = 1'b0;
        shift_setting = AVERAGE_SHIFT_RESET;
        swap_setting = 1'b0;

        add_pix_row(MODE_LOAD,   16'h0000, 16'h0000, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h0000, 16'hFFFF, 1'b1, 16'h0000);
        add_pix_row(MODE_LOAD,   16'hFFFF, 16'hFFFF, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'hFFFF, 16'h0000, 1'b1, 16'h8000);
        add_pix_row(MODE_LOAD,   16'h1234, 16'h00FF, 1'b0, 16'h0000);
        add_pix_row(MODE_ADD,    16'h1234, 16'hFF00, 1'b0, 16'h0000);
        add_pix_row(MODE_ADD,    16'h1234, 16'hFFFF, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h1234, 16'h0000, 1'b1, 16'hFFFF);
        add_pix_row(MODE_READ,   16'h1234, 16'h0000, 1'b1, 16'h8000);
        add_pix_row(MODE_UNUSED, 16'h1234, 16'hABCD, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h1234, 16'h0000, 1'b1, 16'h4000);
        add_pix_row(MODE_LOAD,   16'h0001, 16'h0003, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h0001, 16'h0000, 1'b1, 16'h0002);
        add_pix_row(MODE_UNUSED, 16'hAAAA, 16'h5555, 1'b0, 16'h0000);
        add_pix_row(MODE_LOAD,   16'h5555, 16'hAAAA, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h5555, 16'h0000, 1'b1, 16'h5555);
        add_pix_row(MODE_LOAD,   16'h0002, 16'h0001, 1'b0, 16'h0000);
        add_pix_row(MODE_ADD,    16'h0002, 16'h0001, 1'b0, 16'h0000);
        add_pix_row(MODE_ADD,    16'h0002, 16'h8000, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h0002, 16'h0000, 1'b1, 16'h4001);
        add_cfg_row(ADDR_AVERAGE_SHIFT, 32'd7);
        add_cfg_row(ADDR_BYTE_SWAP, 32'd1);
        add_pix_row(MODE_LOAD,   16'h0009, 16'h00FF, 1'b0, 16'h0000);
        add_pix_row(MODE_ADD,    16'h0009, 16'hFFFF, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h0009, 16'h0000, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'h0009, 16'h0000, 1'b0, 16'h0000);
        add_pix_row(MODE_LOAD,   16'hFFFF, 16'h0180, 1'b0, 16'h0000);
        add_pix_row(MODE_READ,   16'hFFFF, 16'h0000, 1'b0, 16'h0000);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                wait_for_averages(1'b1);
                apb_write(row.addr, row.data);
            end
            else
            begin
                send_pixel(row.item, row.typed, row.result);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_for_averages(1'b1);
            if (ph == 0)
                new_shift = 3'd1;
            else if (ph == 1)
                new_shift = 3'd7;
            else
                new_shift = 3'($urandom_range(1, 7));
            apb_write(ADDR_AVERAGE_SHIFT, {29'd0, new_shift});
            apb_write(ADDR_BYTE_SWAP, (ph == 0) ? 32'd0 : 32'($urandom_range(0, 1)));

            gaps_on = (ph != 2);
            burst_left = 0;
            if (ph == 2)
                stall_style = STALL_NONE;
            else
                stall_style = stall_style_t'($urandom_range(0, 2));
            stall_pct = $urandom_range(10, 70);
            stall_period = $urandom_range(2, 16);
            stall_duty = $urandom_range(1, stall_period - 1);

            npix = 160 >> new_shift;
            if (npix == 0)
                npix = 1;
            frames = 1 << new_shift;
            pixel_pool.delete();
            for (int p = 0; p < npix; p++)
                pixel_pool.push_back(16'($urandom));

            for (int f = 0; f < frames; f++)
            begin
                foreach (pixel_pool[p])
                begin
                    send_plain((f == 0) ? MODE_LOAD : MODE_ADD, pixel_pool[p],
                               random_sample());
                    if ($urandom_range(0, 15) == 0)
                        send_noise(pixel_pool);
                end
            end

            if (ph == RANDOM_PHASES / 2)
                wait_for_averages(1'b0);

            for (int p = 0; p < npix; p++)
                send_plain(MODE_READ, pixel_pool[$urandom_range(0, npix - 1)], 16'($urandom));
            repeat (10) send_noise(pixel_pool);
        end

        wait_for_averages(1'b1);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && averages_due.size() == 0)
            $display("tb_raw_frame_accumulate_average_core OK");
        else
            $display("tb_raw_frame_accumulate_average_core NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
sv/rfaa_pkg.sv
sv/rfaa_ram.sv
sv/raw_frame_accumulate_average.sv
sv/rfaa_checker.sv
sim/tb_raw_frame_accumulate_average_core.sv
